// File: sv/utf8_utf16_length_line_counter_defines.svh
// Assertion macros for the UTF-8 length and line counter.
`ifndef UTF8_UTF16_LENGTH_LINE_COUNTER_DEFINES_SVH
`define UTF8_UTF16_LENGTH_LINE_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define U8LC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u8lc: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define U8LC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u8lc: next-cycle check failed");

`endif

// File: sv/u8lc_pkg.sv
// Constants for the UTF-8 length and line counter.
package u8lc_pkg;

    // operation codes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic REG_MAX_CHARS = 1'b0;
    localparam logic REG_MAX_LINES = 1'b1;

    localparam logic [31:0] MAX_CHARS_RST = 32'd1048576;
    localparam logic [31:0] MAX_LINES_RST = 32'd65536;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    localparam logic [7:0] ASCII_MAX   = 8'h7f;
    localparam logic [7:0] LEAD2_MIN   = 8'hc2;
    localparam logic [7:0] LEAD2_MAX   = 8'hdf;
    localparam logic [7:0] LEAD3_MIN   = 8'he0;
    localparam logic [7:0] LEAD3_MAX   = 8'hef;
    localparam logic [7:0] LEAD4_MIN   = 8'hf0;
    localparam logic [7:0] LEAD4_MAX   = 8'hf4;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_BMP_MAX = 21'h00ffff;
    localparam logic [20:0] CP_SUR_LO  = 21'h00d800;
    localparam logic [20:0] CP_SUR_HI  = 21'h00dfff;
    localparam logic [20:0] CP_MAX     = 21'h10ffff;

endpackage

// File: sv/utf8_utf16_length_line_counter.sv
// UTF-8 to UTF-16 length counter with line counting and limits.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+--------------------------------------
//   in      | i_in_valid  | o_in_ready  | i_operation, i_data_byte
//   out     | o_out_valid | i_out_ready | o_stopped, o_too_large,
//           |             |             | o_char_count, o_line_count
//   cfg     | i_cfg_we    | (none)      | i_cfg_idx, i_cfg_data
//
// One item per clock while the output is not stalled; an accepted item enters the input register.
// The per-item decode and count update runs combinationally from the input register
// into the state registers, which also serve as the result register.
// Synchronous active-low reset clears all counters and loads default limits.
// A stalled output holds the state; the input register still takes one item if it is empty.
module utf8_utf16_length_line_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_stopped,
    output logic        o_too_large,
    output logic [31:0] o_char_count,
    output logic [31:0] o_line_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import u8lc_pkg::*;

    `include "utf8_utf16_length_line_counter_defines.svh"

    logic [31:0] r_max_chars, r_max_lines;

    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [7:0]  r_byte;
    logic        r_out_valid;

    logic [7:0]  r_held [0:2];
    logic [2:0]  r_held_cnt, r_exp_len;
    logic        r_last_cr, r_halted, r_ovf;
    logic [31:0] r_lines, r_units;

    logic [7:0]  n_held [0:2];
    logic [2:0]  n_held_cnt, n_exp_len;
    logic        n_last_cr, n_halted, n_ovf;
    logic [31:0] n_lines, n_units;

    logic        w_move, w_step;
    logic        w_is_sep, w_is_cont;
    logic [2:0]  w_lead_len;
    logic [20:0] w_cp;
    logic        w_cp_ok;
    logic [2:0]  w_seq_units;
    logic [31:0] w_lines_inc;
    logic        add_first;
    logic [2:0]  add_n, w_total;
    logic [32:0] w_sum_a, w_sum_b;
    logic        w_ok_a, w_ok_b, line_hit;

    assign w_move      = !r_out_valid || i_out_ready;
    assign w_step      = r_in_valid && w_move;
    assign o_in_ready  = !r_in_valid || w_move;
    assign o_out_valid = r_out_valid;
    assign o_stopped    = r_halted;
    assign o_too_large  = r_ovf;
    assign o_char_count = r_units;
    assign o_line_count = r_lines;

    // byte classification
    always_comb begin
        w_is_sep  = (r_byte == CH_CR) || (r_byte == CH_LF);
        w_is_cont = (r_byte[7:6] == CONT_TAG);
        if (r_byte >= LEAD2_MIN && r_byte <= LEAD2_MAX) begin
            w_lead_len = 3'd2;
        end else if (r_byte >= LEAD3_MIN && r_byte <= LEAD3_MAX) begin
            w_lead_len = 3'd3;
        end else if (r_byte >= LEAD4_MIN && r_byte <= LEAD4_MAX) begin
            w_lead_len = 3'd4;
        end else begin
            w_lead_len = 3'd0;  // ASCII (<= ASCII_MAX) or bad lead: one unit
        end
    end

    // code point of a sequence completed by r_byte
    always_comb begin
        case (r_exp_len)
            3'd2: begin
                w_cp = {10'd0, r_held[0][4:0], r_byte[5:0]};
            end
            3'd3: begin
                w_cp = {5'd0, r_held[0][3:0], r_held[1][5:0], r_byte[5:0]};
            end
            default: begin
                w_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], r_byte[5:0]};
            end
        endcase
        w_cp_ok = !((r_exp_len == 3'd3 && w_cp < CP_MIN3) ||
                    (r_exp_len == 3'd4 && w_cp < CP_MIN4) ||
                    (w_cp >= CP_SUR_LO && w_cp <= CP_SUR_HI) ||
                    (w_cp > CP_MAX));
        if (!w_cp_ok) begin
            w_seq_units = r_exp_len;
        end else if (w_cp > CP_BMP_MAX) begin
            w_seq_units = 3'd2;
        end else begin
            w_seq_units = 3'd1;
        end
    end

    assign w_lines_inc = (r_lines == '1) ? r_lines : r_lines + 32'd1;

    // next state
    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_exp_len  = r_exp_len;
        n_last_cr  = r_last_cr;
        n_lines    = r_lines;
        n_units    = r_units;
        n_halted   = r_halted;
        n_ovf      = r_ovf;
        add_first  = 1'b0;   // flush of an open sequence
        add_n      = 3'd0;   // units from the byte itself
        line_hit   = 1'b0;

        case (r_op)
            OP_BYTE: begin
                if (!r_halted) begin
                    if (w_is_sep) begin
                        if (r_held_cnt != 3'd0) begin
                            add_first  = 1'b1;
                            n_held_cnt = 3'd0;
                        end
                        if (r_byte == CH_LF && r_last_cr) begin
                            n_last_cr = 1'b0;
                        end else begin
                            n_last_cr = (r_byte == CH_CR);
                            n_lines   = w_lines_inc;
                            line_hit  = (w_lines_inc >= r_max_lines);
                        end
                    end else begin
                        n_last_cr = 1'b0;
                        if (r_held_cnt == 3'd0 || !w_is_cont) begin
                            add_first  = (r_held_cnt != 3'd0);
                            n_held_cnt = 3'd0;
                            if (w_lead_len == 3'd0) begin
                                add_n = 3'd1;
                            end else begin
                                n_held[0]  = r_byte;
                                n_held_cnt = 3'd1;
                                n_exp_len  = w_lead_len;
                            end
                        end else if (r_held_cnt + 3'd1 < r_exp_len) begin
                            n_held[r_held_cnt[1:0]] = r_byte;
                            n_held_cnt = r_held_cnt + 3'd1;
                        end else begin
                            n_held_cnt = 3'd0;
                            add_n      = w_seq_units;
                        end
                    end
                end
            end
            OP_FINISH: begin
                if (r_held_cnt != 3'd0) begin
                    add_first  = 1'b1;
                    n_held_cnt = 3'd0;
                end
            end
            OP_CLEAR: begin
                n_held[0]  = '0;
                n_held[1]  = '0;
                n_held[2]  = '0;
                n_held_cnt = '0;
                n_exp_len  = '0;
                n_last_cr  = 1'b0;
                n_lines    = '0;
                n_units    = '0;
                n_halted   = 1'b0;
                n_ovf      = 1'b0;
            end
            default: begin
            end
        endcase

        // a flush unit is followed by at most one more unit, so both sums come
        // straight from the current count
        w_total = {2'd0, add_first} + add_n;
        w_sum_a = {1'b0, r_units} + 33'd1;
        w_sum_b = {1'b0, r_units} + {30'd0, w_total};
        w_ok_a  = (w_sum_a <= {1'b0, r_max_chars});
        w_ok_b  = (w_sum_b <= {1'b0, r_max_chars});

        if (add_first && !w_ok_a) begin
            n_halted = 1'b1;
            n_ovf    = 1'b1;
        end else if (add_n != 3'd0 && !w_ok_b) begin
            n_halted = 1'b1;
            n_ovf    = 1'b1;
            if (add_first) begin
                n_units = w_sum_a[31:0];
            end
        end else if (add_first || add_n != 3'd0) begin
            n_units = w_sum_b[31:0];
        end

        if (line_hit) begin
            n_halted = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= MAX_CHARS_RST;
            r_max_lines <= MAX_LINES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_CHARS: r_max_chars <= i_cfg_data;
                REG_MAX_LINES: r_max_lines <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_operation;
            r_byte <= i_data_byte;
        end
    end

    // counting state, doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held[0]   <= '0;
            r_held[1]   <= '0;
            r_held[2]   <= '0;
            r_held_cnt  <= '0;
            r_exp_len   <= '0;
            r_last_cr   <= 1'b0;
            r_lines     <= '0;
            r_units     <= '0;
            r_halted    <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            if (w_move) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_held     <= n_held;
                r_held_cnt <= n_held_cnt;
                r_exp_len  <= n_exp_len;
                r_last_cr  <= n_last_cr;
                r_lines    <= n_lines;
                r_units    <= n_units;
                r_halted   <= n_halted;
                r_ovf      <= n_ovf;
            end
        end
    end

    `U8LC_ASSERT_NOW(a_ovf_halts, r_ovf, r_halted)
    `U8LC_ASSERT_NOW(a_open_seq_short, r_held_cnt != 3'd0, r_held_cnt < r_exp_len)
    `U8LC_ASSERT_NEXT(a_count_holds_on_stall, !w_step, $stable(r_units) && $stable(r_lines))
    `U8LC_ASSERT_NEXT(a_halted_ignores_byte, w_step && r_op == OP_BYTE && r_halted,
                      $stable(r_units) && $stable(r_lines))

endmodule
